### rtl/rc_channel_frame_packer_assert.svh
// Assertion helpers for the frame packer
`ifndef RC_CHANNEL_FRAME_PACKER_ASSERT_SVH
`define RC_CHANNEL_FRAME_PACKER_ASSERT_SVH

// same-cycle implication
`define RCFP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcfp: implication check failed");

// next-cycle implication
`define RCFP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcfp: next-cycle check failed");

`endif

### rtl/rcfp_pkg.sv
package rcfp_pkg;

   localparam int CHANNELS_DEF = 16;
   localparam int US_W         = 16;
   localparam int CLAMP_W      = 11;
   localparam int RAW_W        = 11;
   localparam int BYTE_W       = 8;
   localparam int CSR_IDX_W    = 8;
   localparam int CSR_DATA_W   = 16;
   localparam int QUEUE_DEPTH  = 4;
   localparam int PROD_W       = 21;
   localparam int ACC_W        = 18;
   localparam int CNT_W        = 5;
   localparam int PEND_W       = 7;

   localparam logic [CLAMP_W-1:0] US_BASE   = 11'd988;
   localparam logic [CLAMP_W-1:0] RAW_SCALE = 11'd1639;
   localparam logic [PROD_W-1:0]  RAW_ROUND = 21'd512;
   localparam logic [RAW_W-1:0]   RAW_MIN   = 11'd172;
   localparam logic [RAW_W-1:0]   RAW_MAX   = 11'd1811;
   localparam logic [BYTE_W-1:0]  LEN_BYTE  = 8'h18;
   localparam logic [BYTE_W-1:0]  CRC_POLY  = 8'hD5;

   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_MIN  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_MAX  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_BYTE  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_TYPE = 8'd3;

   localparam logic [CLAMP_W-1:0] PULSE_MIN_RST  = 11'd988;
   localparam logic [CLAMP_W-1:0] PULSE_MAX_RST  = 11'd2012;
   localparam logic [BYTE_W-1:0]  SYNC_BYTE_RST  = 8'd200;
   localparam logic [BYTE_W-1:0]  FRAME_TYPE_RST = 8'd22;

   typedef struct packed {
      logic [CLAMP_W-1:0] pulse_min_us;
      logic [CLAMP_W-1:0] pulse_max_us;
      logic [BYTE_W-1:0]  sync_byte;
      logic [BYTE_W-1:0]  frame_type_byte;
   } cfg_type;

   typedef struct packed {
      logic [RAW_W-1:0] raw;
      logic             first;
      logic             last;
   } ent_type;

   function automatic logic [BYTE_W-1:0] crc_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[BYTE_W-1]) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

### rtl/rcfp_queue.sv
module rcfp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rcfp_pkg::ent_type  wdata,
   input  logic               pop,
   output rcfp_pkg::ent_type  rdata,
   output logic               full,
   output logic               empty
);

   localparam int DEPTH = rcfp_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rcfp_pkg::ent_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

### rtl/rcfp_front.sv
module rcfp_front #(
   parameter int CHANNELS = rcfp_pkg::CHANNELS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rcfp_pkg::cfg_type            cfg,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [rcfp_pkg::US_W-1:0]    req_tdata,
   output logic                         q_push,
   output rcfp_pkg::ent_type            q_wdata,
   input  logic                         q_full
);

   localparam int CH_W = $clog2(CHANNELS);
   localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

   logic [CH_W-1:0]                  ch_ff, ch_in;
   logic                             stg_valid_ff, stg_valid_in;
   logic [rcfp_pkg::CLAMP_W-1:0]     stg_u_ff, stg_u_in;
   logic                             stg_first_ff, stg_last_ff;
   logic                             accept;

   logic [rcfp_pkg::US_W-1:0]        lo_us;
   logic [rcfp_pkg::CLAMP_W-1:0]     diff;
   logic [rcfp_pkg::PROD_W-1:0]      prod;
   logic [rcfp_pkg::RAW_W:0]         raw_wide;
   logic [rcfp_pkg::RAW_W-1:0]       raw;

   assign q_push     = stg_valid_ff && !q_full;
   assign req_tready = !stg_valid_ff || q_push;
   assign accept     = req_tvalid && req_tready;

   // clamp: lower limit first, upper limit second
   always_comb begin
      lo_us = (req_tdata < rcfp_pkg::US_W'(cfg.pulse_min_us)) ?
              rcfp_pkg::US_W'(cfg.pulse_min_us) : req_tdata;
      stg_u_in = (lo_us > rcfp_pkg::US_W'(cfg.pulse_max_us)) ?
                 cfg.pulse_max_us : lo_us[rcfp_pkg::CLAMP_W-1:0];
   end

   always_comb begin
      diff     = stg_u_ff - rcfp_pkg::US_BASE;
      prod     = rcfp_pkg::PROD_W'(diff) * rcfp_pkg::PROD_W'(rcfp_pkg::RAW_SCALE)
                 + rcfp_pkg::RAW_ROUND;
      raw_wide = {1'b0, prod[rcfp_pkg::PROD_W-1:10]} + (rcfp_pkg::RAW_W+1)'(rcfp_pkg::RAW_MIN);
      if (stg_u_ff < rcfp_pkg::US_BASE) begin
         raw = rcfp_pkg::RAW_MIN;
      end else if (raw_wide > (rcfp_pkg::RAW_W+1)'(rcfp_pkg::RAW_MAX)) begin
         raw = rcfp_pkg::RAW_MAX;
      end else begin
         raw = raw_wide[rcfp_pkg::RAW_W-1:0];
      end
      q_wdata.raw   = raw;
      q_wdata.first = stg_first_ff;
      q_wdata.last  = stg_last_ff;
   end

   always_comb begin
      ch_in        = ch_ff;
      stg_valid_in = stg_valid_ff;
      if (accept) begin
         ch_in        = (ch_ff == CH_LAST) ? '0 : ch_ff + 1'b1;
         stg_valid_in = 1'b1;
      end else if (q_push) begin
         stg_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff        <= '0;
         stg_valid_ff <= 1'b0;
      end else begin
         ch_ff        <= ch_in;
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_u_ff     <= stg_u_in;
         stg_first_ff <= (ch_ff == '0);
         stg_last_ff  <= (ch_ff == CH_LAST);
      end
   end

endmodule

### rtl/rcfp_back.sv
module rcfp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  rcfp_pkg::cfg_type             cfg,
   input  logic                          q_empty,
   input  rcfp_pkg::ent_type             q_rdata,
   output logic                          q_pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [rcfp_pkg::BYTE_W-1:0]   rsp_tdata,
   output logic                          rsp_tlast,
   output logic                          rsp_tuser
);

   localparam logic [2:0] PH_SYNC = 3'd0;
   localparam logic [2:0] PH_LEN  = 3'd1;
   localparam logic [2:0] PH_TYPE = 3'd2;
   localparam logic [2:0] PH_DATA = 3'd3;
   localparam logic [2:0] PH_CRC  = 3'd4;

   logic                          busy_ff, busy_in;
   logic [2:0]                    phase_ff, phase_in;
   logic                          last_ff, last_in;
   logic [rcfp_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic [rcfp_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [rcfp_pkg::PEND_W-1:0]   pend_ff, pend_in;
   logic [2:0]                    pc_ff, pc_in;
   logic [rcfp_pkg::BYTE_W-1:0]   crc_ff, crc_in;

   logic                          out_valid_ff, out_valid_in;
   logic [rcfp_pkg::BYTE_W-1:0]   out_byte_ff, out_byte_in;
   logic                          out_last_ff, out_last_in;
   logic                          out_fend_ff, out_fend_in;

   logic                          out_free, emit, done, fend;
   logic [rcfp_pkg::BYTE_W-1:0]   byte_val;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign emit       = busy_ff && out_free;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_fend_ff;

   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      last_in  = last_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      pend_in  = pend_ff;
      pc_in    = pc_ff;
      crc_in   = crc_ff;
      byte_val = '0;
      done     = 1'b0;
      fend     = 1'b0;

      if (emit) begin
         unique case (phase_ff)
            PH_SYNC: begin
               byte_val = cfg.sync_byte;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               byte_val = rcfp_pkg::LEN_BYTE;
               phase_in = PH_TYPE;
            end
            PH_TYPE: begin
               byte_val = cfg.frame_type_byte;
               crc_in   = rcfp_pkg::crc_update('0, cfg.frame_type_byte);
               phase_in = PH_DATA;
            end
            PH_DATA: begin
               byte_val = acc_ff[rcfp_pkg::BYTE_W-1:0];
               crc_in   = rcfp_pkg::crc_update(crc_ff, acc_ff[rcfp_pkg::BYTE_W-1:0]);
               acc_in   = acc_ff >> rcfp_pkg::BYTE_W;
               cnt_in   = cnt_ff - rcfp_pkg::CNT_W'(rcfp_pkg::BYTE_W);
               if (cnt_in < rcfp_pkg::CNT_W'(rcfp_pkg::BYTE_W)) begin
                  pend_in = acc_in[rcfp_pkg::PEND_W-1:0];
                  pc_in   = cnt_in[2:0];
                  if (last_ff) begin
                     phase_in = PH_CRC;
                  end else begin
                     done = 1'b1;
                  end
               end
            end
            PH_CRC: begin
               byte_val = crc_ff;
               fend     = 1'b1;
               crc_in   = '0;
               pend_in  = '0;
               pc_in    = '0;
               done     = 1'b1;
            end
            default: begin
               done = 1'b1;
            end
         endcase
      end

      q_pop = !q_empty && (!busy_ff || done);

      if (q_pop) begin
         busy_in  = 1'b1;
         last_in  = q_rdata.last;
         phase_in = q_rdata.first ? PH_SYNC : PH_DATA;
         acc_in   = rcfp_pkg::ACC_W'(pend_in) | (rcfp_pkg::ACC_W'(q_rdata.raw) << pc_in);
         cnt_in   = rcfp_pkg::CNT_W'(pc_in) + rcfp_pkg::CNT_W'(rcfp_pkg::RAW_W);
      end else if (done) begin
         busy_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_fend_in  = out_fend_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = byte_val;
         out_last_in  = done;
         out_fend_in  = fend;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= PH_SYNC;
         pend_ff      <= '0;
         pc_ff        <= '0;
         crc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         pend_ff      <= pend_in;
         pc_ff        <= pc_in;
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      acc_ff      <= acc_in;
      cnt_ff      <= cnt_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_fend_ff <= out_fend_in;
   end

endmodule

### rtl/rc_channel_frame_packer.sv
// Path from a taken input word to its first output word, queue empty: staging register,
// queue, packer state register, output register. Throughput: one output word per cycle
// while rsp_tready is high; a channel gives 1 to 4 words, 26 per frame of 16 channels.
// Input takes a new word every cycle while the 4-entry queue has room.
// Reset: synchronous, active high; clears frame position, CRC, queue and output,
// and loads the register defaults. No clearing pass.
`include "rc_channel_frame_packer_assert.svh"

module rc_channel_frame_packer #(
   parameter int CHANNELS = rcfp_pkg::CHANNELS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rcfp_pkg::US_W-1:0]        req_tdata,    // [15:0] pulse_us
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rcfp_pkg::BYTE_W-1:0]      rsp_tdata,    // [7:0] out_byte
   output logic                             rsp_tlast,
   output logic                             rsp_tuser,    // [0] frame_end
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rcfp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rcfp_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   rcfp_pkg::cfg_type cfg_ff;
   rcfp_pkg::ent_type q_wdata, q_rdata;
   logic              q_push, q_pop, q_full, q_empty;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_min_us    <= rcfp_pkg::PULSE_MIN_RST;
         cfg_ff.pulse_max_us    <= rcfp_pkg::PULSE_MAX_RST;
         cfg_ff.sync_byte       <= rcfp_pkg::SYNC_BYTE_RST;
         cfg_ff.frame_type_byte <= rcfp_pkg::FRAME_TYPE_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            rcfp_pkg::CSR_PULSE_MIN:
               cfg_ff.pulse_min_us    <= csr_wdata[rcfp_pkg::CLAMP_W-1:0];
            rcfp_pkg::CSR_PULSE_MAX:
               cfg_ff.pulse_max_us    <= csr_wdata[rcfp_pkg::CLAMP_W-1:0];
            rcfp_pkg::CSR_SYNC_BYTE:
               cfg_ff.sync_byte       <= csr_wdata[rcfp_pkg::BYTE_W-1:0];
            rcfp_pkg::CSR_FRAME_TYPE:
               cfg_ff.frame_type_byte <= csr_wdata[rcfp_pkg::BYTE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   rcfp_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_push     (q_push),
      .q_wdata    (q_wdata),
      .q_full     (q_full)
   );

   rcfp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .full  (q_full),
      .empty (q_empty)
   );

   rcfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_rdata    (q_rdata),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   `RCFP_ASSERT_IMP(a_pop_not_empty, clock, reset, q_pop, !q_empty)
   `RCFP_ASSERT_IMP(a_push_not_full, clock, reset, q_push, !q_full)
   `RCFP_ASSERT_IMP(a_crc_ends_run, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast)
   `RCFP_ASSERT_NXT(a_push_fills, clock, reset, q_push && !q_pop, !q_empty)

endmodule

### tb/sv/frame_byte_checker.sv
module frame_byte_checker
   import rcfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [US_W-1:0]       req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [BYTE_W-1:0]     rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  rsp_tuser,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    errors,
   output int                    backlog
);

   typedef struct {
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              fend;
   } frame_byte_type;

   frame_byte_type    frame_bytes_due[$];
   frame_byte_type    due;
   cfg_type           cfg;
   logic [3:0]        chan_idx;
   logic [BYTE_W-1:0] pend_bits;
   logic [2:0]        pend_cnt;
   logic [BYTE_W-1:0] frame_crc;
   int                err_count;

   function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] c;
      c = crc ^ b;
      repeat (BYTE_W) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic logic [RAW_W-1:0] width_to_raw(input logic [US_W-1:0] us);
      int unsigned u;
      int unsigned raw;
      u = us;
      if (u < cfg.pulse_min_us) u = cfg.pulse_min_us;
      if (u > cfg.pulse_max_us) u = cfg.pulse_max_us;
      if (u < 988) return RAW_MIN;
      raw = ((u - 988) * 1639 + 512) / 1024 + 172;
      if (raw > 1811) raw = 1811;
      return raw[RAW_W-1:0];
   endfunction

   function automatic void emit(input logic [BYTE_W-1:0] b, input logic fend);
      frame_byte_type w;
      w.data = b;
      w.last = 1'b0;
      w.fend = fend;
      frame_bytes_due.push_back(w);
   endfunction

   function automatic void predict_channel(input logic [US_W-1:0] us);
      logic [31:0] acc;
      int unsigned cnt;
      if (chan_idx == 0) begin
         emit(cfg.sync_byte, 1'b0);
         emit(LEN_BYTE, 1'b0);
         emit(cfg.frame_type_byte, 1'b0);
         frame_crc = crc8_step(8'h00, cfg.frame_type_byte);
         pend_bits = '0;
         pend_cnt  = '0;
      end
      acc = {24'd0, pend_bits} | ({21'd0, width_to_raw(us)} << pend_cnt);
      cnt = pend_cnt + 11;
      while (cnt >= 8) begin
         emit(acc[7:0], 1'b0);
         frame_crc = crc8_step(frame_crc, acc[7:0]);
         acc = acc >> 8;
         cnt = cnt - 8;
      end
      pend_bits = acc[7:0];
      pend_cnt  = cnt[2:0];
      if (chan_idx == CHANNELS_DEF - 1) begin
         emit(frame_crc, 1'b1);
         chan_idx  = '0;
         pend_bits = '0;
         pend_cnt  = '0;
         frame_crc = '0;
      end else begin
         chan_idx = chan_idx + 1'b1;
      end
      frame_bytes_due[frame_bytes_due.size() - 1].last = 1'b1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg.pulse_min_us    = PULSE_MIN_RST;
         cfg.pulse_max_us    = PULSE_MAX_RST;
         cfg.sync_byte       = SYNC_BYTE_RST;
         cfg.frame_type_byte = FRAME_TYPE_RST;
         chan_idx  = '0;
         pend_bits = '0;
         pend_cnt  = '0;
         frame_crc = '0;
         frame_bytes_due.delete();
      end else begin
         if (req_tvalid && req_tready) predict_channel(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (frame_bytes_due.size() == 0) begin
               $display("%0t: unexpected word: data %h last %b end %b",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser);
               err_count++;
            end else begin
               due = frame_bytes_due.pop_front();
               if (rsp_tdata !== due.data || rsp_tlast !== due.last
                   || rsp_tuser !== due.fend) begin
                  $display({"%0t: word mismatch: expected data %h last %b end %b,",
                            " got data %h last %b end %b"},
                           $time, due.data, due.last, due.fend,
                           rsp_tdata, rsp_tlast, rsp_tuser);
                  err_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PULSE_MIN:  cfg.pulse_min_us    = csr_wdata[CLAMP_W-1:0];
               CSR_PULSE_MAX:  cfg.pulse_max_us    = csr_wdata[CLAMP_W-1:0];
               CSR_SYNC_BYTE:  cfg.sync_byte       = csr_wdata[BYTE_W-1:0];
               CSR_FRAME_TYPE: cfg.frame_type_byte = csr_wdata[BYTE_W-1:0];
               default: ;
            endcase
         end
      end
      errors  <= err_count;
      backlog <= frame_bytes_due.size();
   end

endmodule

### tb/sv/tb.sv
module tb;
   import rcfp_pkg::*;

   localparam int QUIET_LIMIT = 2000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [US_W-1:0]       req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [BYTE_W-1:0]     rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int errors;
   int backlog;
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int quiet_cycles  = 0;

   rc_channel_frame_packer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   frame_byte_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .errors     (errors),
      .backlog    (backlog)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_limits(input int unsigned lo, input int unsigned hi,
                             input int unsigned sync, input int unsigned ftype);
      write_reg(CSR_PULSE_MIN, lo);
      write_reg(CSR_PULSE_MAX, hi);
      write_reg(CSR_SYNC_BYTE, sync);
      write_reg(CSR_FRAME_TYPE, ftype);
      csr_valid <= 1'b0;
   endtask

   task automatic send_pulse(input int unsigned us);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= us[US_W-1:0];
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (backlog != 0);
      repeat (8) @(posedge clock);
   endtask

   function automatic int unsigned pick_limit();
      case ($urandom_range(3))
         0:       return 988;
         1:       return 2012;
         default: return $urandom_range(2012, 988);
      endcase
   endfunction

   function automatic int unsigned pick_byte();
      case ($urandom_range(3))
         0:       return 0;
         1:       return 255;
         default: return $urandom_range(255);
      endcase
   endfunction

   function automatic int unsigned pick_pulse();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 15) return $urandom_range(65535);
      if (r < 22) return $urandom_range(1050, 940);
      if (r < 29) return $urandom_range(2060, 1950);
      return $urandom_range(2100, 900);
   endfunction

   int unsigned edge_pulses[16] = '{0, 65535, 987, 988, 989, 1500, 2011, 2012,
                                    2013, 2047, 2048, 1024, 32768, 1, 16'hAAAA, 16'h5555};

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full frame at reset defaults
      foreach (edge_pulses[i]) send_pulse(edge_pulses[i]);
      drain();

      // crossed limits, fresh frame
      set_limits(1600, 1200, 0, 255);
      send_pulse(1000);
      send_pulse(1400);
      send_pulse(1800);
      send_pulse(65535);
      drain();

      // mid-frame change: new sync and type only apply from next frame
      set_limits(1500, 1500, 255, 0);
      send_pulse(0);
      send_pulse(1500);
      send_pulse(65535);
      send_pulse(2012);
      drain();

      for (int mode = 0; mode < 4; mode++) begin
         case (mode)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 61; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 61; end
            default: begin req_idle_pct = 16; rsp_stall_pct = 16; end
         endcase
         for (int sub = 0; sub < 2; sub++) begin
            set_limits(pick_limit(), pick_limit(), pick_byte(), pick_byte());
            repeat (13) send_pulse(pick_pulse());
            drain();
         end
      end

      repeat (10) @(posedge clock);
      if (errors == 0 && backlog == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
